// ----- sv/csvfs_pkg.sv -----
package csvfs_pkg;

    localparam int          MAX_FIELDS_DEFAULT = 256;
    localparam int          RESULT_DEPTH       = 4;

    localparam logic [7:0]  CH_BACKSLASH   = 8'd92;
    localparam logic [7:0]  CH_QUOTE       = 8'd34;
    localparam logic [7:0]  CH_COMMA       = 8'd44;
    localparam logic [7:0]  CH_FIRST_PRINT = 8'd32;

    typedef struct packed {
        logic       rec_end;
        logic [7:0] field_num;
        logic       field_end;
        logic [7:0] data;
    } t_result;

    // up to two results from one input byte; res0 is delivered first
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- sv/csvfs_parse.sv -----
module csvfs_parse #(
    parameter int MAX_FIELDS = csvfs_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_space,
    output csvfs_pkg::t_push  o_push
);

    localparam int CAP = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

    logic       r_drop_high;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_quotes;
    logic       r_escape;
    logic [7:0] r_field;

    logic       n_quotes;
    logic       n_escape;
    logic [7:0] n_field;
    logic       advance;
    logic       emit_data;
    logic       emit_comma;
    logic       emit_first;
    logic [7:0] field_after;
    csvfs_pkg::t_result first_res;
    csvfs_pkg::t_result rec_res;

    assign advance    = r_in_valid && i_space;
    assign o_in_ready = !r_in_valid || i_space;

    always_comb begin
        n_quotes   = r_quotes;
        n_escape   = r_escape;
        emit_data  = 1'b0;
        emit_comma = 1'b0;
        if (r_escape) begin
            n_escape  = 1'b0;
            emit_data = 1'b1;
        end else if (r_in_byte < csvfs_pkg::CH_FIRST_PRINT
                     || (r_drop_high && r_in_byte[7])) begin
            // control byte, or high byte while drop_high is set: dropped
        end else if (r_in_byte == csvfs_pkg::CH_QUOTE) begin
            n_quotes = !r_quotes;
        end else if (r_in_byte == csvfs_pkg::CH_BACKSLASH && !r_quotes) begin
            n_escape = 1'b1;
        end else if (r_in_byte == csvfs_pkg::CH_COMMA && !r_quotes) begin
            emit_comma = 1'b1;
        end else begin
            emit_data = 1'b1;
        end

        field_after = (emit_comma && r_field < 8'(CAP)) ? r_field + 8'd1 : r_field;
        n_field     = field_after;
        if (r_in_last) begin
            n_quotes = 1'b0;
            n_escape = 1'b0;
            n_field  = '0;
        end

        emit_first = emit_data || emit_comma;

        first_res.rec_end   = 1'b0;
        first_res.field_num = r_field;
        first_res.field_end = emit_comma;
        first_res.data      = emit_comma ? 8'd0 : r_in_byte;

        // record end carries the number after a trailing comma bumped it
        rec_res.rec_end   = 1'b1;
        rec_res.field_num = field_after;
        rec_res.field_end = 1'b1;
        rec_res.data      = 8'd0;

        o_push.num  = advance ? (2'(emit_first) + 2'(r_in_last)) : 2'd0;
        o_push.res0 = emit_first ? first_res : rec_res;
        o_push.res1 = rec_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_high <= 1'b1;
            r_in_valid  <= 1'b0;
            r_quotes    <= 1'b0;
            r_escape    <= 1'b0;
            r_field     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_drop_high <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_quotes <= n_quotes;
                r_escape <= n_escape;
                r_field  <= n_field;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

endmodule

// ----- sv/csvfs_fifo.sv -----
module csvfs_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csvfs_pkg::t_push    i_push,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output csvfs_pkg::t_result  o_res
);

    localparam int AW = $clog2(csvfs_pkg::RESULT_DEPTH);

    csvfs_pkg::t_result r_mem [csvfs_pkg::RESULT_DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW:0]        r_count;

    logic               pop;
    logic [AW-1:0]      wr_ptr_1;

    assign pop      = o_valid && i_ready;
    assign o_valid  = r_count != '0;
    assign o_space  = r_count <= (AW+1)'(csvfs_pkg::RESULT_DEPTH - 2);
    assign o_res    = r_mem[r_rd_ptr];
    assign wr_ptr_1 = r_wr_ptr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push.num);
            r_rd_ptr <= r_rd_ptr + AW'(pop);
            r_count  <= r_count + (AW+1)'(i_push.num) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

endmodule

// ----- sv/csv_record_field_splitter_core.sv -----
// CSV field splitter: takes one record byte per transaction (tlast on the
// record's final byte) and returns the cleaned field bytes plus a field-end
// transaction for each field, the final one flagged with tlast. A byte is taken
// every cycle while the result queue has room for two results; a byte that
// yields two results (a data byte or comma that ends the record) writes both
// into the queue together, and the output side moves one result per cycle
// while tready is high. A byte passes the input register, then a four-entry
// result queue that also lets input continue while the output is stalled.
module csv_record_field_splitter_core #(
    parameter int MAX_FIELDS = csvfs_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,     // drop_high_bytes
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] in_byte
    input  logic        i_s_axis_tlast,    // in_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,    // [7:0] out_byte, [15:8] field_number
    output logic        o_m_axis_tuser,    // is_field_end
    output logic        o_m_axis_tlast     // record_end
);

    csvfs_pkg::t_push   push;
    csvfs_pkg::t_result head;
    logic               space;

    csvfs_parse #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_byte    (i_s_axis_tdata),
        .i_in_last    (i_s_axis_tlast),
        .o_in_ready   (o_s_axis_tready),
        .i_space      (space),
        .o_push       (push)
    );

    csvfs_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_space(space),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_res  (head)
    );

    assign o_m_axis_tdata = {head.field_num, head.data};
    assign o_m_axis_tuser = head.field_end;
    assign o_m_axis_tlast = head.rec_end;

endmodule

// ----- sv/csvfs_checker.sv -----
module csvfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // field-end transactions carry a zero data byte
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("field end with nonzero byte");

    // record end is always also a field end
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("record end without field end");

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output transaction changed");

endmodule

bind csv_record_field_splitter_core csvfs_checker u_csvfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);
